/* design/lmce_pkg.sv */
package lmce_pkg;

    localparam int COL_W       = 7;
    localparam int CHAR_W      = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int IDX_W       = 3;

    localparam logic [CHAR_W-1:0] CH_BS        = 7'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 7'h09;
    localparam logic [CHAR_W-1:0] CH_NL        = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 7'h20;
    localparam logic [CHAR_W-1:0] CH_DASH      = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LT        = 7'h3C;
    localparam logic [CHAR_W-1:0] CH_GT        = 7'h3E;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 7'h5C;
    localparam logic [CHAR_W-1:0] CH_DEL       = 7'h7F;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_ARROW = 2'd1,
        KIND_OCTAL = 2'd2
    } kind_t;

    typedef struct packed {
        logic              wrap;
        kind_t             kind;
        logic [CHAR_W-1:0] chr;
    } entry_t;

endpackage

/* design/lmce_front.sv */
module lmce_front
    import lmce_pkg::*;
#(
    parameter int WRAP_COLUMN = 72
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_line_start,
    input  logic              q_full,
    output logic              push,
    output entry_t            push_entry
);

    logic              list_mode_reg;
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [COL_W-1:0]  col_base;
    logic [COL_W-1:0]  col_inc;
    logic              wrap;
    logic              is_arrow;
    logic              is_octal;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign push      = in_valid && in_ready;

    always_comb
    begin
        col_base = in_line_start ? '0 : column_reg;
        col_inc  = col_base + COL_W'(1);
        wrap     = list_mode_reg && (col_inc >= COL_W'(WRAP_COLUMN));
        is_arrow = (in_char == CH_TAB) || (in_char == CH_BS);
        is_octal = !is_arrow && (((in_char < CH_SPACE) && (in_char != CH_NL))
                   || (in_char == CH_DEL));

        column_next = col_base;
        if (list_mode_reg)
        begin
            column_next = wrap ? '0 : col_inc;
            if (is_octal)
                column_next = column_next + COL_W'(3);
        end

        push_entry.wrap = wrap;
        push_entry.chr  = in_char;
        if (!list_mode_reg)
            push_entry.kind = KIND_PLAIN;
        else if (is_arrow)
            push_entry.kind = KIND_ARROW;
        else if (is_octal)
            push_entry.kind = KIND_OCTAL;
        else
            push_entry.kind = KIND_PLAIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_mode_reg <= 1'b0;
            column_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                list_mode_reg <= cfg_data;
            if (push)
                column_reg <= column_next;
        end
    end

endmodule

/* design/lmce_queue.sv */
module lmce_queue
    import lmce_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* design/lmce_back.sv */
module lmce_back
    import lmce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  entry_t            head_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_byte,
    output logic              out_last
);

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              load;
    logic [IDX_W-1:0]  pre_len;
    logic [IDX_W-1:0]  body_len;
    logic [IDX_W-1:0]  j;
    logic [CHAR_W-1:0] cur_byte;
    logic              cur_last;

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && cur_last;

    always_comb
    begin
        pre_len = head_entry.wrap ? IDX_W'(2) : '0;
        unique case (head_entry.kind)
            KIND_ARROW: body_len = IDX_W'(3);
            KIND_OCTAL: body_len = IDX_W'(4);
            default:    body_len = IDX_W'(1);
        endcase
        j        = idx_reg - pre_len;
        cur_last = (idx_reg == pre_len + body_len - IDX_W'(1));

        if (head_entry.wrap && idx_reg == '0)
            cur_byte = CH_BACKSLASH;
        else if (head_entry.wrap && idx_reg == IDX_W'(1))
            cur_byte = CH_NL;
        else
        begin
            unique case (head_entry.kind)
                KIND_ARROW:
                begin
                    if (j == '0)
                        cur_byte = CH_DASH;
                    else if (j == IDX_W'(1))
                        cur_byte = CH_BS;
                    else
                        cur_byte = (head_entry.chr == CH_TAB) ? CH_GT : CH_LT;
                end
                KIND_OCTAL:
                begin
                    if (j == '0)
                        cur_byte = CH_BACKSLASH;
                    else if (j == IDX_W'(1))
                        cur_byte = CH_ZERO + CHAR_W'(head_entry.chr[6]);
                    else if (j == IDX_W'(2))
                        cur_byte = CH_ZERO + CHAR_W'(head_entry.chr[5:3]);
                    else
                        cur_byte = CH_ZERO + CHAR_W'(head_entry.chr[2:0]);
                end
                default: cur_byte = head_entry.chr;
            endcase
        end

        idx_next = idx_reg;
        if (load)
            idx_next = cur_last ? '0 : idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < IDX_W'(6))
        else $error("byte index out of range");

    a_idx_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid)
        else $error("escape in progress without a queued entry");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && out_last_reg))
        else $error("entry retired without a final byte");

endmodule

/* design/list_mode_char_escaper.sv */
// List-mode character escaper.
// Input stream: s_axis_tdata carries one 7-bit character, s_axis_tuser the
// line-start flag that clears the column count first.
// Output stream: m_axis_tdata carries one byte of the listed form, m_axis_tlast
// marks the final byte for that character (1 to 6 bytes per character).
// Config channel: cfg_data is the list-mode bit, written when cfg_valid is
// high (cfg_ready is always high); write only while the block is idle.
// Front end classifies the character and updates the column on acceptance,
// a 4-entry queue holds classified characters, the back end sequences the
// bytes into an output register at one byte per cycle while not stalled.
// An accepted character is written into the queue, and then its first byte
// is loaded into the output register. Throughput: one output byte per cycle
// while the receiver is ready, so one character per cycle for plain text.
// Reset clears list mode, the column and the queue.
// A stalled receiver holds the output register; the queue keeps accepting
// until full, then s_axis_tready drops.
module list_mode_char_escaper
    import lmce_pkg::*;
#(
    parameter int WRAP_COLUMN = 72
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,        // [0] list_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [6:0] character, [7] zero
    input  logic       s_axis_tuser,    // [0] line_start
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [6:0] out_byte, [7] zero
    output logic       m_axis_tlast
);

    logic              q_full;
    logic              push;
    entry_t            push_entry;
    logic              pop;
    logic              head_valid;
    entry_t            head_entry;
    logic [CHAR_W-1:0] out_byte;

    lmce_front #(
        .WRAP_COLUMN (WRAP_COLUMN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_char       (s_axis_tdata[CHAR_W-1:0]),
        .in_line_start (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    lmce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    lmce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_byte};

endmodule

/* tb/escaper_checker.sv */
`timescale 1ns / 100ps

module escaper_checker
    import lmce_pkg::*;
#(
    parameter int WRAP_COLUMN = 72
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tuser,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    output int         mismatches,
    output int         bytes_owed
);

    typedef struct packed {
        logic [CHAR_W-1:0] out_byte;
        logic              last;
    } listed_byte_t;

    listed_byte_t      listing_q[$];
    logic              mode_on;
    logic [COL_W-1:0]  col;
    int                fail_tally;

    // Expands one character into its listed bytes and tracks the column.
    task automatic list_character(input logic [CHAR_W-1:0] ch, input logic line_start);
        listed_byte_t seq[$];
        if (line_start)
            col = '0;
        if (mode_on)
        begin
            col = col + 7'd1;
            if (col >= WRAP_COLUMN)
            begin
                col = '0;
                seq.push_back('{CH_BACKSLASH, 1'b0});
                seq.push_back('{CH_NL, 1'b0});
            end
            if (ch == CH_TAB || ch == CH_BS)
            begin
                seq.push_back('{CH_DASH, 1'b0});
                seq.push_back('{CH_BS, 1'b0});
                seq.push_back('{(ch == CH_TAB) ? CH_GT : CH_LT, 1'b0});
            end
            else if ((ch < CH_SPACE && ch != CH_NL) || ch == CH_DEL)
            begin
                seq.push_back('{CH_BACKSLASH, 1'b0});
                seq.push_back('{CH_ZERO + {6'b0, ch[6]}, 1'b0});
                seq.push_back('{CH_ZERO + {4'b0, ch[5:3]}, 1'b0});
                seq.push_back('{CH_ZERO + {4'b0, ch[2:0]}, 1'b0});
                col = col + 7'd3;
            end
            else
                seq.push_back('{ch, 1'b0});
        end
        else
            seq.push_back('{ch, 1'b0});
        seq[seq.size() - 1].last = 1'b1;
        foreach (seq[i])
            listing_q.push_back(seq[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        listed_byte_t want;
        if (!rst_n)
        begin
            mode_on = 1'b0;
            col = '0;
            fail_tally = 0;
            listing_q.delete();
            mismatches <= 0;
            bytes_owed <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (listing_q.size() == 0)
                begin
                    $error("output transaction with nothing expected: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    fail_tally++;
                end
                else
                begin
                    want = listing_q.pop_front();
                    if (m_axis_tdata[6:0] !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, m_axis_tdata[6:0]);
                        fail_tally++;
                    end
                    if (m_axis_tdata[7] !== 1'b0)
                    begin
                        $error("tdata pad: expected 0, actual %b", m_axis_tdata[7]);
                        fail_tally++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, m_axis_tlast);
                        fail_tally++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                mode_on = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                list_character(s_axis_tdata[6:0], s_axis_tuser);
            mismatches <= fail_tally;
            bytes_owed <= listing_q.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import lmce_pkg::*;

    localparam int WRAP_COLUMN = 72;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;       // [6:0] character, [7] zero
    logic       s_axis_tuser;       // [0] line_start
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;       // [6:0] out_byte, [7] zero
    logic       m_axis_tlast;

    int mismatches;
    int bytes_owed;
    int gap_pct = 20;
    int stall_pct = 20;
    int cycles = 0;

    list_mode_char_escaper #(
        .WRAP_COLUMN(WRAP_COLUMN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    escaper_checker #(
        .WRAP_COLUMN(WRAP_COLUMN)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .mismatches(mismatches),
        .bytes_owed(bytes_owed)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic line_start);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ch};
        s_axis_tuser  <= line_start;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Skewed towards controls and escapes so every listing path is hit often
    function automatic logic [CHAR_W-1:0] pick_character();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return r[0] ? CH_TAB : CH_BS;
        else if (r < 28)
            return CHAR_W'($urandom_range(0, 31));
        else if (r < 34)
            return r[0] ? CH_DEL : CH_NL;
        else
            return CHAR_W'($urandom_range(32, 126));
    endfunction

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through after reset
        send_char(7'h00, 1'b1);
        send_char(CH_DEL, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(7'h41, 1'b1);
        drain();

        write_mode(1'b1);
        send_char(CH_TAB, 1'b1);
        send_char(CH_BS, 1'b0);
        send_char(CH_NL, 1'b0);
        send_char(7'h00, 1'b0);
        send_char(7'h1F, 1'b0);
        send_char(CH_DEL, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(7'h7E, 1'b0);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(7'h15, 1'b1);
        send_char(7'h2A, 1'b1);
        send_char(7'h55, 1'b0);
        send_char(7'h1B, 1'b0);
        send_char(7'h07, 1'b0);
        send_char(7'h1E, 1'b0);
        send_char(7'h0B, 1'b0);
        send_char(7'h0C, 1'b0);
        send_char(7'h0D, 1'b0);
        send_char(7'h10, 1'b0);
        drain();

        // long lines to reach the wrap column
        for (int n = 0; n < 80; n++)
        begin
            if (n % 20 == 0)
            begin
                gap_pct   = $urandom_range(0, 40);
                stall_pct = $urandom_range(0, 40);
            end
            send_char(pick_character(), $urandom_range(0, 59) == 0);
        end
        drain();

        write_mode(1'b0);
        for (int n = 0; n < 30; n++)
            send_char(pick_character(), $urandom_range(0, 3) == 0);
        drain();

        write_mode(1'b1);
        gap_pct   = 0;
        stall_pct = 0;
        for (int n = 0; n < 40; n++)
            send_char(pick_character(), $urandom_range(0, 59) == 0);
        drain();

        if (mismatches == 0 && bytes_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* list_mode_char_escaper.f */
design/lmce_pkg.sv
design/lmce_front.sv
design/lmce_queue.sv
design/lmce_back.sv
design/list_mode_char_escaper.sv
tb/escaper_checker.sv
tb/testbench.sv
